// File: hw/rtl/fmbs_pkg.sv
// ============================================================================
// fmbs_pkg
// Shared types for the sorted-key table search block: controller states and
// the command and status groups between controller and datapath.
// ============================================================================
package fmbs_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP
    } fmbs_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic write;   // store key_value at entry_index
        logic load;    // open a search: bounds, key, match flag
        logic read;    // read the probe entry at the midpoint
        logic step;    // narrow the bounds from the read entry
        logic finish;  // register the result and raise the strobe
    } fmbs_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic range_empty;  // lower bound has met the upper bound
    } fmbs_sts_t;

endpackage

// File: hw/rtl/fmbs_ctrl.sv
// ============================================================================
// fmbs_ctrl
// Search sequencer: takes commands, runs probes (a read in ST_CHECK, then a
// compare in ST_CMP) until the search range is empty, then closes the transaction.
// ============================================================================
module fmbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mode,
    input  fmbs_pkg::fmbs_sts_t sts,
    output fmbs_pkg::fmbs_cmd_t cmd,
    output logic              busy
);
    import fmbs_pkg::*;

    fmbs_state_t state_reg;
    fmbs_state_t state_next;
    logic        accept;

    assign accept = start && !busy;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.range_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.write  = start && !mode;
                cmd.load   = start && mode;
            end
            ST_CHECK:
            begin
                cmd.read   = !sts.range_empty;
                cmd.finish = sts.range_empty;
            end
            ST_CMP:
            begin
                cmd.step   = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hw/rtl/fmbs_datapath.sv
// ============================================================================
// fmbs_datapath
// Key table memory, entry count register, search bounds and result
// registers for the lower-bound search.
// ============================================================================
module fmbs_datapath #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 16,
    parameter int IDX_W       = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fmbs_pkg::fmbs_cmd_t  cmd,
    output fmbs_pkg::fmbs_sts_t  sts,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     entry_count,
    input  logic [IDX_W-1:0]     entry_index,
    input  logic [KEY_WIDTH-1:0] key_value,
    output logic                 done,
    output logic                 found,
    output logic [IDX_W-1:0]     match_index
);
    import fmbs_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     hi_reg;
    logic                 eq_reg;
    logic                 done_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     match_index_reg;
    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     count_sat;
    logic                 wr_in_range;

    // Entry count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= entry_count;
        end
    end

    // Midpoint, saturated count and write range check
    assign mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign count_sat   = (count_reg > DEPTH_C) ? DEPTH_C : count_reg;
    assign wr_in_range = (CNT_W'(entry_index) < DEPTH_C);
    assign sts.range_empty = !(lo_reg < hi_reg);

    // Key table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range)
        begin
            key_mem[entry_index] <= key_value;
        end
        if (cmd.read)
        begin
            rd_data_reg <= key_mem[mid[IDX_W-1:0]];
        end
    end

    // Search bounds; eq_reg tells whether the entry at hi_reg equals the key
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key_value;
            lo_reg  <= '0;
            hi_reg  <= count_sat;
            eq_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (rd_data_reg < key_reg)
            begin
                lo_reg <= mid + CNT_W'(1);
            end
            else
            begin
                hi_reg <= mid;
                eq_reg <= (rd_data_reg == key_reg);
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found_reg       <= eq_reg;
            match_index_reg <= eq_reg ? lo_reg[IDX_W-1:0] : '0;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;

    // A bounds update only follows a probe into a non-empty range
    a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !sts.range_empty)
        else $error("bounds update with an empty range");

    // Bounds never cross after an update
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    // A search closes only once the bounds have met
    a_finish_met: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (lo_reg == hi_reg))
        else $error("search closed with open bounds");

    // A miss reports index zero
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (found_reg || (match_index_reg == '0)))
        else $error("miss reported a nonzero index");

endmodule

// File: hw/rtl/first_match_binary_search.sv
// ============================================================================
// first_match_binary_search
// Sorted key table with write and lower-bound search commands; a search
// returns a found flag and the index of the first entry equal to the key.
// ============================================================================
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------
//  command   start / busy              mode, entry_index, key_value
//  result    done (one-cycle strobe)   found, match_index
//  config    cfg_valid / cfg_ready     entry_count
//
//  A write command is stored from the idle state; busy stays low and the
//  next command may follow at once. A search runs P probes with
//  P <= floor(log2(entry_count)) + 1, paced by the single read port of the
//  key table: one registered read, then one compare, per probe. done rises
//  at the same edge at which busy falls.
//  Reset clears the controller, the strobe and entry_count; the table is
//  not cleared. The receiver cannot stall; cfg_ready is always high.
//
module first_match_binary_search #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  mode,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        entry_index,
    input  logic [KEY_WIDTH-1:0]                  key_value,
    output logic                                  done,
    output logic                                  found,
    output logic [$clog2(TABLE_DEPTH)-1:0]        match_index,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [$clog2(TABLE_DEPTH + 1)-1:0]    entry_count
);
    import fmbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    fmbs_cmd_t cmd;
    fmbs_sts_t sts;

    // Configuration is taken on any cycle
    assign cfg_ready = 1'b1;

    // Sequencer
    fmbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Table and search datapath
    fmbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .entry_count (entry_count),
        .entry_index (entry_index),
        .key_value   (key_value),
        .done        (done),
        .found       (found),
        .match_index (match_index)
    );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for first_match_binary_search
// Drives write and search commands into the sorted key table, keeps its own
// copy of the table and of entry_count, and predicts every search result with
// a lower-bound search. Each result strobe is checked against the oldest
// outstanding prediction. Directed tests cover the empty table, duplicate
// runs, the key extremes, an unsorted table and the saturated count. A long
// random run follows: sorted fills with random content, then searches, with
// stray writes mixed in.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_DEPTH  = 256;
    localparam int KEY_W        = 16;
    localparam int IDX_W        = 8;
    localparam int CNT_W        = 9;
    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_TAIL   = 100;   // final items sent with no gaps
    localparam int DRAIN_CYCLES = 30;    // longer than the slowest search
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef struct packed
    {
        logic             found;
        logic [IDX_W-1:0] index;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic mode = OP_WRITE;
    logic [IDX_W-1:0] entry_index = '0;
    logic [KEY_W-1:0] key_value = '0;
    logic cfg_valid = 1'b0;
    logic [CNT_W-1:0] entry_count = '0;
    logic busy;
    logic done;
    logic found;
    logic [IDX_W-1:0] match_index;
    logic cfg_ready;

    // Shadow of the block state
    logic [KEY_W-1:0] key_store [TABLE_DEPTH];
    logic [CNT_W-1:0] count_in_use = '0;

    lookup_result_t pending_lookups[$];
    int error_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int quiet_start = 32'h7FFF_FFFF;   // no gaps from this item on
    bit gaps_on = 1'b0;

    first_match_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_W)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .entry_index (entry_index),
        .key_value   (key_value),
        .done        (done),
        .found       (found),
        .match_index (match_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .entry_count (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lower-bound search over the entries in use; count saturates at depth
    function automatic lookup_result_t lower_bound_lookup(logic [KEY_W-1:0] key);
        lookup_result_t res;
        int n;
        int lo;
        int hi;
        int mid;
        n = (count_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_in_use);
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (key_store[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        res.found = (lo < n) && (key_store[lo] == key);
        res.index = res.found ? IDX_W'(lo) : '0;
        return res;
    endfunction

    // One command transaction; returns at the accepting edge
    task automatic issue_command(op_t op, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key);
        int gap;
        gap = (gaps_on && (items_sent < quiet_start) && $urandom_range(0, 3) == 0) ?
              $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        mode <= op;
        entry_index <= idx;
        key_value <= key;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (op == OP_WRITE)
            key_store[idx] = key;
        else
            pending_lookups.push_back(lower_bound_lookup(key));
    endtask

    // Stop issuing, wait for all results, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_lookups.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(logic [CNT_W-1:0] n);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        entry_count <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        count_in_use = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes non-decreasing keys into entries 0..n-1; spread bounds the random step size
    task automatic fill_sorted(int n, int spread, int first_key);
        int i;
        int k;
        k = first_key;
        for (i = 0; i < n; i++)
        begin
            issue_command(OP_WRITE, IDX_W'(i), KEY_W'(k));
            k = k + $urandom_range(0, spread);
            if (k > 65535)
                k = 65535;
        end
    endtask

    task automatic search(logic [KEY_W-1:0] key);
        issue_command(OP_SEARCH, IDX_W'($urandom_range(0, 255)), key);
    endtask

    // Result checker: every strobe must match the oldest prediction
    always @(posedge clk)
    begin
        lookup_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("result strobe with no search outstanding");
                error_count++;
            end
            else
            begin
                exp_res = pending_lookups.pop_front();
                if (found !== exp_res.found)
                begin
                    $error("found: expected %0d, actual %0d", exp_res.found, found);
                    error_count++;
                end
                if (match_index !== exp_res.index)
                begin
                    $error("match_index: expected %0d, actual %0d",
                           exp_res.index, match_index);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("first_match_binary_search verification failed");
            $finish;
        end
    end

    // Count of zero: nothing can match
    task automatic test_empty_table();
        set_entry_count('0);
        search('0);
        search('1);
    endtask

    // Short table with duplicate runs, key extremes, a shrunk count and
    // finally an out-of-order entry
    task automatic test_sorted_prefix();
        logic [KEY_W-1:0] keys [8];
        int i;
        keys = '{16'd0, 16'd0, 16'd170, 16'd170, 16'd170, 16'd500, 16'hFFFE, 16'hFFFF};
        for (i = 0; i < 8; i++)
            issue_command(OP_WRITE, IDX_W'(i), keys[i]);
        issue_command(OP_WRITE, 8'd255, 16'hFFFF);
        set_entry_count(9'd8);
        search(16'd0);
        search(16'd170);
        search(16'd171);
        search(16'd100);
        search(16'hFFFE);
        search(16'hFFFF);
        set_entry_count(9'd1);
        search(16'd0);
        search(16'd170);
        set_entry_count(9'd8);
        issue_command(OP_WRITE, 8'd3, 16'd5);
        search(16'd5);
        search(16'd170);
    endtask

    // Whole table in use; counts above the depth saturate
    task automatic test_full_table();
        int i;
        fill_sorted(TABLE_DEPTH, 3, 0);
        set_entry_count(9'd256);
        for (i = 0; i < 6; i++)
            search(key_store[$urandom_range(0, TABLE_DEPTH - 1)]);
        search(key_store[0]);
        search(key_store[TABLE_DEPTH - 1]);
        search(16'hFFFF);
        set_entry_count(9'd511);
        search(key_store[TABLE_DEPTH - 1]);
        search(key_store[$urandom_range(0, TABLE_DEPTH - 1)]);
        search(KEY_W'($urandom()));
        set_entry_count(9'd300);
        search(key_store[$urandom_range(0, TABLE_DEPTH - 1)]);
        search(key_store[$urandom_range(0, TABLE_DEPTH - 1)] + 16'd1);
    endtask

    // Phases of sorted fill, count update, then mostly searches on that table
    task automatic test_random_mix();
        int first_item;
        int r;
        int n_cfg;
        int n_fill;
        int queries;
        int j;
        bit phase_gaps;
        logic [KEY_W-1:0] key;
        first_item = items_sent;
        quiet_start = first_item + RANDOM_ITEMS - QUIET_TAIL;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                n_cfg = 0;
            else if (r < 55)
                n_cfg = $urandom_range(1, 16);
            else if (r < 80)
                n_cfg = $urandom_range(17, 64);
            else if (r < 93)
                n_cfg = $urandom_range(65, 256);
            else
                n_cfg = $urandom_range(257, 511);
            n_fill = (n_cfg > TABLE_DEPTH) ? TABLE_DEPTH : n_cfg;
            phase_gaps = ($urandom_range(0, 2) != 0);
            gaps_on = phase_gaps && (items_sent - first_item < RANDOM_ITEMS - QUIET_TAIL);

            if (n_fill > 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    fill_sorted(n_fill, 2, $urandom_range(0, 65535));
                else
                    fill_sorted(n_fill, 131070 / n_fill, $urandom_range(0, 255));
            end
            set_entry_count(CNT_W'(n_cfg));

            queries = $urandom_range(10, 40);
            for (j = 0; j < queries; j++)
            begin
                gaps_on = phase_gaps &&
                          (items_sent - first_item < RANDOM_ITEMS - QUIET_TAIL);
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    // stray write; may leave the table out of order
                    issue_command(OP_WRITE, IDX_W'($urandom_range(0, 255)),
                                  KEY_W'($urandom()));
                end
                else
                begin
                    if (n_fill > 0 && r < 60)
                        key = key_store[$urandom_range(0, n_fill - 1)];
                    else if (n_fill > 0 && r < 75)
                        key = key_store[$urandom_range(0, n_fill - 1)] +
                              (($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF);
                    else
                        key = KEY_W'($urandom());
                    search(key);
                end
            end
        end
        gaps_on = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        gaps_on = 1'b1;
        test_empty_table();
        test_sorted_prefix();
        test_full_table();
        test_random_mix();
        wait_idle();
        if (error_count == 0)
            $display("first_match_binary_search verification clean");
        else
            $display("first_match_binary_search verification failed");
        $finish;
    end

endmodule
